/* hw/rtl/irqlb_pkg.sv */
// ============================================================================
// irqlb_pkg
// Shared types and constants of the interrupt load balancer.
// ============================================================================
package irqlb_pkg;

  localparam int DEF_MAX_CORES = 16;
  localparam int DEF_IRQ_LINES = 16;

  localparam int COUNT_W     = 64;
  localparam int INTERVAL_W  = 16;
  localparam int MOD_DIGIT_W = 4;    // dividend bits retired per remainder cycle
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_W-1:0] NEAR_FULL = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam logic              RST_BAL_EN     = 1'b0;
  localparam logic              RST_SYM_MODE   = 1'b0;
  localparam logic [4:0]        RST_CORE_COUNT = 5'd1;
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAL_EN     = 2'd0,
    CFG_SYM_MODE   = 2'd1,
    CFG_CORE_COUNT = 2'd2,
    CFG_INTERVAL   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [3:0] core_id;
    logic [3:0] irq_line;
  } item_t;

  typedef struct packed {
    logic       eoi_to_local_apic;
    logic       route_valid;
    logic [3:0] route_core;
    logic       counts_cleared;
  } result_t;

endpackage

/* hw/rtl/irq_load_balancer.sv */
// ============================================================================
// irq_load_balancer
// End-of-interrupt steering and least-count rebalancing of IRQ lines.
// ============================================================================
//
//   Channel   Signals                          Direction  Handshake
//   --------  -------------------------------  ---------  ----------------------
//   command   start, busy, item                in         start & !busy
//   result    done, result                     out        done strobe, one cycle
//   config    cfg_we, cfg_index, cfg_data      in         cfg_we, no wait
//
// An interrupt whose line or core is out of range gives its result in the
// cycle after acceptance. Otherwise the counter is read and then updated, and
// a rebalance check adds a pass of the remainder unit, a scan of the line's
// counters of scan cores through the memory port and, when saturation is seen,
// a clearing of those counters, where scan is min(core_count, MAX_CORES). The
// single memory port sets the scan and clear length.
// Reset: a clearing pass writes zero to all MAX_CORES*IRQ_LINES counters, one
// per cycle, while busy is high.
// The result side has no back pressure; a beat is shown for exactly one cycle.
// ============================================================================
module irq_load_balancer
  import irqlb_pkg::*;
#(
  parameter int MAX_CORES = DEF_MAX_CORES,
  parameter int IRQ_LINES = DEF_IRQ_LINES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_CORES * IRQ_LINES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCAN_W = $clog2(MAX_CORES + 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INC,
    S_MOD,
    S_SCAN,
    S_CLEAR
  } state_t;

  state_t state;

  // Configuration registers.
  logic                  balancing_enabled;
  logic                  symmetric_mode;
  logic [4:0]            core_count;
  logic [INTERVAL_W-1:0] balance_interval;

  // Per-beat working registers.
  logic [3:0]         irq_q;
  logic [ADDR_W-1:0]  own_addr;
  logic [ADDR_W-1:0]  init_addr;
  logic [SCAN_W-1:0]  idx;
  logic [SCAN_W-1:0]  cmp_idx;
  logic               cmp_valid;
  logic [COUNT_W-1:0] minc;
  logic [3:0]         best;
  logic               clear_flag;

  // Memory port.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [COUNT_W-1:0] mem_wdata;
  logic [COUNT_W-1:0] mem_rdata;

  logic               mod_start;
  logic               mod_done;
  logic               mod_rem_zero;

  logic               accept;
  logic               in_range;
  logic [ADDR_W-1:0]  entry_addr;
  logic [ADDR_W-1:0]  col_addr;
  logic [COUNT_W-1:0] cnt_inc;
  logic               need_bal;
  logic [SCAN_W-1:0]  scan_n;
  logic               cmp_less;
  logic               cmp_sat;
  logic               scan_last;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = (int'(item.core_id) < MAX_CORES) && (int'(item.irq_line) < IRQ_LINES);

  assign entry_addr = ADDR_W'(int'(item.core_id) * IRQ_LINES + int'(item.irq_line));
  assign col_addr   = ADDR_W'(int'(idx) * IRQ_LINES + int'(irq_q));

  // The count just read, plus one; it wraps through zero on overflow.
  assign cnt_inc  = mem_rdata + COUNT_W'(1);
  assign need_bal = (cnt_inc != '0) && balancing_enabled && (balance_interval != '0);

  // Cores beyond the instantiated ones are not scanned.
  assign scan_n = (int'(core_count) > MAX_CORES) ? SCAN_W'(MAX_CORES) : SCAN_W'(core_count);

  // Scan comparison on the data read in the previous cycle. An all-ones
  // entry can never become the minimum since the running minimum starts there.
  assign cmp_less  = (mem_rdata < minc);
  assign cmp_sat   = (mem_rdata >= NEAR_FULL);
  assign scan_last = ((cmp_idx + SCAN_W'(1)) == scan_n);

  assign mod_start = (state == S_INC) && need_bal;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = own_addr;
    mem_wdata = '0;
    case (state)
      S_INIT: begin
        mem_we   = 1'b1;
        mem_addr = init_addr;
      end
      S_IDLE: begin
        mem_addr = entry_addr;
      end
      S_INC: begin
        mem_we    = 1'b1;
        mem_addr  = own_addr;
        mem_wdata = cnt_inc;
      end
      S_SCAN: begin
        mem_addr = col_addr;
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = col_addr;
      end
      default: begin
        mem_addr = own_addr;
      end
    endcase
  end

  irqlb_count_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  irqlb_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cnt_inc),
    .divisor  (balance_interval),
    .done     (mod_done),
    .rem_zero (mod_rem_zero)
  );

  // Configuration writes land at any time; software is to write only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      balancing_enabled <= RST_BAL_EN;
      symmetric_mode    <= RST_SYM_MODE;
      core_count        <= RST_CORE_COUNT;
      balance_interval  <= RST_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BAL_EN:     balancing_enabled <= cfg_data[0];
        CFG_SYM_MODE:   symmetric_mode    <= cfg_data[0];
        CFG_CORE_COUNT: core_count        <= cfg_data[4:0];
        CFG_INTERVAL:   balance_interval  <= cfg_data[INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Main sequencer. Every path from an accepted beat back to idle emits exactly one result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_addr <= init_addr + ADDR_W'(1);
          if (init_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            irq_q    <= item.irq_line;
            own_addr <= entry_addr;
            if (in_range) begin
              state <= S_INC;
            end else begin
              result.eoi_to_local_apic <= symmetric_mode;
              result.route_valid       <= 1'b0;
              result.route_core        <= '0;
              result.counts_cleared    <= 1'b0;
              done                     <= 1'b1;
            end
          end
        end

        S_INC: begin
          // The write-back of the new count happens in this cycle.
          if (need_bal) begin
            state <= S_MOD;
          end else begin
            result.eoi_to_local_apic <= symmetric_mode;
            result.route_valid       <= 1'b0;
            result.route_core        <= '0;
            result.counts_cleared    <= 1'b0;
            done                     <= 1'b1;
            state                    <= S_IDLE;
          end
        end

        S_MOD: begin
          idx        <= '0;
          cmp_valid  <= 1'b0;
          minc       <= ALL_ONES;
          best       <= '0;
          clear_flag <= 1'b0;
          if (mod_done) begin
            if (!mod_rem_zero) begin
              result.eoi_to_local_apic <= symmetric_mode;
              result.route_valid       <= 1'b0;
              result.route_core        <= '0;
              result.counts_cleared    <= 1'b0;
              done                     <= 1'b1;
              state                    <= S_IDLE;
            end else if (scan_n == '0) begin
              // Nothing to scan: the route goes to core zero.
              result.eoi_to_local_apic <= symmetric_mode;
              result.route_valid       <= 1'b1;
              result.route_core        <= '0;
              result.counts_cleared    <= 1'b0;
              done                     <= 1'b1;
              state                    <= S_IDLE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // Reads are issued one per cycle and each is compared in the cycle after.
          if (idx < scan_n) begin
            idx       <= idx + SCAN_W'(1);
            cmp_valid <= 1'b1;
            cmp_idx   <= idx;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (cmp_less) begin
              minc <= mem_rdata;
              best <= 4'(cmp_idx);
            end else if (cmp_sat) begin
              clear_flag <= 1'b1;
            end
            if (scan_last) begin
              idx <= '0;
              if (clear_flag || (!cmp_less && cmp_sat)) begin
                state <= S_CLEAR;
              end else begin
                result.eoi_to_local_apic <= symmetric_mode;
                result.route_valid       <= 1'b1;
                result.route_core        <= cmp_less ? 4'(cmp_idx) : best;
                result.counts_cleared    <= 1'b0;
                done                     <= 1'b1;
                state                    <= S_IDLE;
              end
            end
          end
        end

        S_CLEAR: begin
          idx <= idx + SCAN_W'(1);
          if ((idx + SCAN_W'(1)) == scan_n) begin
            result.eoi_to_local_apic <= symmetric_mode;
            result.route_valid       <= 1'b1;
            result.route_core        <= best;
            result.counts_cleared    <= 1'b1;
            done                     <= 1'b1;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/irqlb_count_mem.sv */
// ============================================================================
// irqlb_count_mem
// Single-port synchronous memory holding the per core and IRQ counters.
// ============================================================================
module irqlb_count_mem
  import irqlb_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_CORES * DEF_IRQ_LINES,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [COUNT_W-1:0] wdata,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/irqlb_mod_unit.sv */
// ============================================================================
// irqlb_mod_unit
// Iterative remainder of a 64-bit count by the 16-bit balance interval.
// ============================================================================
module irqlb_mod_unit
  import irqlb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_W-1:0]    dividend,
  input  logic [INTERVAL_W-1:0] divisor,
  output logic                  done,
  output logic                  rem_zero
);

  localparam int STEPS  = COUNT_W / MOD_DIGIT_W;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [COUNT_W-1:0]    dvd;
  logic [INTERVAL_W-1:0] dvs;
  logic [INTERVAL_W-1:0] rem;
  logic [INTERVAL_W-1:0] rem_next;
  logic [INTERVAL_W:0]   trial;
  logic [STEP_W-1:0]     step;
  logic                  active;

  // Restoring remainder, one dividend digit per cycle, MSB first.
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < MOD_DIGIT_W; k++) begin
      trial = {rem_next, dvd[COUNT_W-1-k]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
      end
      rem_next = trial[INTERVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd    <= dividend;
        dvs    <= divisor;
        rem    <= '0;
        step   <= '0;
        active <= 1'b1;
      end else if (active) begin
        rem  <= rem_next;
        dvd  <= dvd << MOD_DIGIT_W;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rem_zero = (rem == '0);

endmodule

/* hw/rtl/irqlb_checker.sv */
// ============================================================================
// irqlb_checker
// Port-level checks of the interrupt load balancer, bound to the top level.
// ============================================================================
module irqlb_checker
  import irqlb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // An accepted beat either starts work or is answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither busy nor answered");

  // A result comes out as the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // No result beat without an earlier acceptance or work in progress.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result beat without a cause");

  // Route and clear fields stay zero when no rebalance decision was made.
  a_no_route_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !result.route_valid) |-> ((result.route_core == '0) && !result.counts_cleared))
    else $error("route fields set without a route");

endmodule

bind irq_load_balancer irqlb_checker u_irqlb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
